// ===== hw/rtl/page_framebuffer_rect_clear_top_assert.svh =====
// Assertion macros shared by the framebuffer modules.
// In synthesis builds every macro expands to nothing.
`ifndef PAGE_FRAMEBUFFER_RECT_CLEAR_TOP_ASSERT_SVH
`define PAGE_FRAMEBUFFER_RECT_CLEAR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PFRC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define PFRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PFRC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PFRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pfrc_pkg.sv =====
package pfrc_pkg;

   localparam int BYTE_W = 8;

   // Widths that hold a start plus a size without overflow.
   localparam int COL_SUM_W = 9;
   localparam int ROW_SUM_W = 8;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [6:0]        column;
      logic [5:0]        row;
      logic [7:0]        width;
      logic [6:0]        height;
      logic [BYTE_W-1:0] write_data;
   } pfrc_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              done_res;
   } pfrc_rsp_type;

   // Status from the sequencer to the top level.
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] read_data;
   } pfrc_stat_type;

endpackage

// ===== hw/rtl/pfrc_ram.sv =====
module pfrc_ram #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [AW-1:0]             waddr,
   input  logic [pfrc_pkg::BYTE_W-1:0] wdata,
   input  logic                      re,
   input  logic [AW-1:0]             raddr,
   output logic [pfrc_pkg::BYTE_W-1:0] rdata
);
   import pfrc_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pfrc_seq.sv =====
`include "page_framebuffer_rect_clear_top_assert.svh"

module pfrc_seq #(
   parameter int COLUMNS = 128,
   parameter int PAGES = 8,
   localparam int DEPTH = COLUMNS * PAGES,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  pfrc_pkg::pfrc_req_type        req,
   output pfrc_pkg::pfrc_stat_type       stat,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [pfrc_pkg::BYTE_W-1:0]   ram_wdata,
   output logic                          ram_re,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [pfrc_pkg::BYTE_W-1:0]   ram_rdata
);
   import pfrc_pkg::*;

   localparam int ROWS = PAGES * 8;
   localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CIW = $clog2(COLUMNS);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_BYTE = 3'd2;
   localparam logic [2:0] S_CRD  = 3'd3;
   localparam logic [2:0] S_CWR  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        init_ff, init_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 inside_ff, inside_in;
   logic [PW-1:0]        page_ff, page_in;
   logic [PW-1:0]        last_page_ff, last_page_in;
   logic [CIW-1:0]       col_ff, col_in;
   logic [CIW-1:0]       col0_ff, col0_in;
   logic [COL_SUM_W-1:0] cend_ff, cend_in;
   logic [5:0]           row_ff, row_in;
   logic [ROW_SUM_W-1:0] rend_ff, rend_in;
   logic [BYTE_W-1:0]    wdata_ff, wdata_in;

   logic [COL_SUM_W-1:0] col_sum_c, cend_c;
   logic [ROW_SUM_W-1:0] row_sum_c, rend_c, row_idx;
   logic                 rect_ok_c, inside_c, last_col_c;
   logic [BYTE_W-1:0]    mask_c;
   logic [AW-1:0]        addr_c;

   // Clipped rectangle bounds, exclusive at the right and bottom.
   always_comb begin
      col_sum_c = COL_SUM_W'(req.column) + COL_SUM_W'(req.width);
      cend_c = (col_sum_c > COL_SUM_W'(COLUMNS)) ? COL_SUM_W'(COLUMNS) : col_sum_c;
      row_sum_c = ROW_SUM_W'(req.row) + ROW_SUM_W'(req.height);
      rend_c = (row_sum_c > ROW_SUM_W'(ROWS)) ? ROW_SUM_W'(ROWS) : row_sum_c;
      rect_ok_c = (COL_SUM_W'(req.column) < COL_SUM_W'(COLUMNS)) &&
                  (ROW_SUM_W'(req.row) < ROW_SUM_W'(ROWS)) &&
                  (req.width != 8'd0) && (req.height != 7'd0);
      inside_c = (COL_SUM_W'(req.column) < COL_SUM_W'(COLUMNS)) &&
                 (ROW_SUM_W'(req.row[5:3]) < ROW_SUM_W'(PAGES));
   end

   // A bit of the current page byte is cleared when its pixel row lies
   // inside the rectangle.
   always_comb begin
      row_idx = '0;
      for (int b = 0; b < BYTE_W; b++) begin
         row_idx = ROW_SUM_W'({page_ff, 3'(b)});
         mask_c[b] = (row_idx >= ROW_SUM_W'(row_ff)) && (row_idx < rend_ff);
      end
   end

   assign addr_c = AW'(int'(page_ff) * COLUMNS + int'(col_ff));
   assign last_col_c = ((COL_SUM_W'(col_ff) + COL_SUM_W'(1)) == cend_ff);

   always_comb begin
      state_in = state_ff;
      init_in = init_ff;
      mode_in = mode_ff;
      inside_in = inside_ff;
      page_in = page_ff;
      last_page_in = last_page_ff;
      col_in = col_ff;
      col0_in = col0_ff;
      cend_in = cend_ff;
      row_in = row_ff;
      rend_in = rend_ff;
      wdata_in = wdata_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = addr_c;
      ram_raddr = addr_c;
      ram_wdata = wdata_ff;

      unique case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            ram_waddr = init_ff;
            ram_wdata = '0;
            if (init_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               init_in = init_ff + AW'(1);
            end
         end
         S_IDLE, S_DONE: begin
            if (accept) begin
               mode_in = req.mode;
               inside_in = inside_c;
               page_in = PW'(req.row >> 3);
               last_page_in = PW'((rend_c - ROW_SUM_W'(1)) >> 3);
               col_in = CIW'(req.column);
               col0_in = CIW'(req.column);
               cend_in = cend_c;
               row_in = req.row;
               rend_in = rend_c;
               wdata_in = req.write_data;
               if (req.mode == MODE_CLEAR) begin
                  state_in = rect_ok_c ? S_CRD : S_DONE;
               end else begin
                  state_in = S_BYTE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_BYTE: begin
            ram_we = (mode_ff == MODE_WRITE) && inside_ff;
            ram_re = (mode_ff == MODE_READ) && inside_ff;
            state_in = S_DONE;
         end
         S_CRD: begin
            ram_re = 1'b1;
            state_in = S_CWR;
         end
         S_CWR: begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata & ~mask_c;
            state_in = S_CRD;
            if (last_col_c) begin
               col_in = col0_ff;
               if (page_ff == last_page_ff) begin
                  state_in = S_DONE;
               end else begin
                  page_in = page_ff + PW'(1);
               end
            end else begin
               col_in = col_ff + CIW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      inside_ff <= inside_in;
      page_ff <= page_in;
      last_page_ff <= last_page_in;
      col_ff <= col_in;
      col0_ff <= col0_in;
      cend_ff <= cend_in;
      row_ff <= row_in;
      rend_ff <= rend_in;
      wdata_ff <= wdata_in;
   end

   always_comb begin
      stat.busy = !((state_ff == S_IDLE) || (state_ff == S_DONE));
      stat.done = (state_ff == S_DONE);
      stat.read_data = ((mode_ff == MODE_READ) && inside_ff) ? ram_rdata : '0;
   end

   `PFRC_ASSERT_IMPL(a_clear_wb_addr, clock, reset, state_ff == S_CWR, ram_waddr == $past(ram_raddr), "clear write-back does not hit the byte just read")
   `PFRC_ASSERT_IMPL(a_clear_bounds, clock, reset, (state_ff == S_CRD) || (state_ff == S_CWR), (page_ff <= last_page_ff) && (COL_SUM_W'(col_ff) < cend_ff), "clear walk left its rectangle")
   `PFRC_ASSERT_NEXT(a_init_no_read, clock, reset, state_ff == S_INIT, (state_ff == S_INIT) || (state_ff == S_IDLE), "init sweep left without reaching idle")

endmodule

// ===== hw/rtl/page_framebuffer_rect_clear_top.sv =====
// Monochrome page framebuffer of COLUMNS x (PAGES*8) pixels, stored as PAGES
// pages of COLUMNS bytes with bit 0 at the top row of each page. A word is
// taken when start is high and busy is low; it writes a byte, reads a byte,
// or clears a rectangle (partial page bytes are masked, clipping at the right
// and bottom edges). Every word yields exactly one result, shown for a single
// cycle with rsp_strobe high; the receiver cannot stall, so it must capture
// the result in that cycle. After reset the block sweeps the whole store to
// zero, one byte per cycle, with busy high. A byte write, byte read or unused
// mode passes through S_BYTE and then S_DONE, where the next word may already
// be taken. A clear does a read-modify-write on every byte that it touches
// (clipped width times pages touched) and then enters S_DONE; an empty or
// out-of-range clear goes straight to S_DONE. The sequencer runs each byte
// as a read state (S_CRD) followed by a write-back state (S_CWR), since the
// store's read data is registered; the result is registered from S_DONE.
`include "page_framebuffer_rect_clear_top_assert.svh"

module page_framebuffer_rect_clear_top #(
   parameter int COLUMNS = 128,
   parameter int PAGES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pfrc_pkg::pfrc_req_type req_data,
   output logic                   rsp_strobe,
   output pfrc_pkg::pfrc_rsp_type rsp_data
);
   import pfrc_pkg::*;

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW = $clog2(DEPTH);

   pfrc_stat_type      stat;
   logic               accept;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   pfrc_rsp_type       rsp_ff, rsp_in;

   // A new word is taken when start is high and the sequencer reports it is free.
   assign accept = start && !stat.busy;
   assign busy = stat.busy;

   pfrc_seq #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .stat     (stat),
      .ram_we   (ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_re   (ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata)
   );

   pfrc_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // The result register holds each result for exactly one cycle. Every
   // operation completes, so done_res is always set.
   always_comb begin
      rsp_valid_in = stat.done;
      rsp_in.read_data = stat.read_data;
      rsp_in.done_res = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `PFRC_ASSERT_IMPL(a_rsp_done, clock, reset, rsp_strobe, rsp_data.done_res,
      "result without its done flag")
   `PFRC_ASSERT_IMPL(a_write_latency, clock, reset,
      accept && (req_data.mode == MODE_WRITE),
      ##3 (rsp_strobe && (rsp_data.read_data == '0)),
      "byte write result missing or nonzero")
   `PFRC_ASSERT_IMPL(a_empty_clear, clock, reset,
      accept && (req_data.mode == MODE_CLEAR) && (req_data.width == 8'd0),
      ##2 rsp_strobe, "empty clear did not finish at once")

endmodule
